### design/stt_pkg.sv
// types, codes and keyword lookup for the source text tokenizer
// no dependencies
`default_nettype none
package stt_pkg;

  localparam int unsigned PosBits  = 16;
  localparam int unsigned LineBits = 16;
  localparam int unsigned KwMaxLen = 6;

  typedef logic [5:0] kind_t;
  typedef logic [1:0] err_t;

  localparam kind_t KEnd    = 6'd0;
  localparam kind_t KErr    = 6'd1;
  localparam kind_t KNum    = 6'd2;
  localparam kind_t KStr    = 6'd3;
  localparam kind_t KIdent  = 6'd4;
  localparam kind_t KLparen = 6'd5;
  localparam kind_t KRparen = 6'd6;
  localparam kind_t KLbrace = 6'd7;
  localparam kind_t KRbrace = 6'd8;
  localparam kind_t KLbrack = 6'd9;
  localparam kind_t KRbrack = 6'd10;
  localparam kind_t KDot    = 6'd11;
  localparam kind_t KComma  = 6'd12;
  localparam kind_t KColon  = 6'd13;
  localparam kind_t KPlus   = 6'd14;
  localparam kind_t KMinus  = 6'd15;
  localparam kind_t KStar   = 6'd16;
  localparam kind_t KSlash  = 6'd17;
  localparam kind_t KGt     = 6'd18;
  localparam kind_t KGe     = 6'd19;
  localparam kind_t KLt     = 6'd20;
  localparam kind_t KLe     = 6'd21;
  localparam kind_t KLpipe  = 6'd22;
  localparam kind_t KOr     = 6'd23;
  localparam kind_t KPipeR  = 6'd24;
  localparam kind_t KAnd    = 6'd25;

  // keywords
  localparam kind_t KwElse   = 6'd26;
  localparam kind_t KwFalse  = 6'd27;
  localparam kind_t KwFn     = 6'd28;
  localparam kind_t KwFor    = 6'd29;
  localparam kind_t KwIf     = 6'd30;
  localparam kind_t KwLet    = 6'd31;
  localparam kind_t KwMatch  = 6'd32;
  localparam kind_t KwPrint  = 6'd33;
  localparam kind_t KwReturn = 6'd34;
  localparam kind_t KwSelf   = 6'd35;
  localparam kind_t KwStruct = 6'd36;
  localparam kind_t KwTrue   = 6'd37;
  localparam kind_t KwWhile  = 6'd38;
  localparam kind_t KwWith   = 6'd39;

  localparam err_t ErrNone  = 2'd0;
  localparam err_t ErrChar  = 2'd1;
  localparam err_t ErrMulti = 2'd2;
  localparam err_t ErrUnter = 2'd3;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_IDENT   = 12'b0000_0000_0010,
    M_INT     = 12'b0000_0000_0100,
    M_INT_DOT = 12'b0000_0000_1000,
    M_FRAC    = 12'b0000_0001_0000,
    M_STRING  = 12'b0000_0010_0000,
    M_COMMENT = 12'b0000_0100_0000,
    M_SLASH   = 12'b0000_1000_0000,
    M_GT      = 12'b0001_0000_0000,
    M_LT      = 12'b0010_0000_0000,
    M_PIPE    = 12'b0100_0000_0000,
    M_AMP     = 12'b1000_0000_0000
  } mode_e;

  typedef struct packed {
    logic                last;
    logic [15:0]         line;
    logic [15:0]         len;
    logic [15:0]         start;
    err_t                err;
    kind_t               kind;
  } tok_t;

  typedef logic [KwMaxLen-1:0][7:0] word_t;

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h28:   k = KLparen;
      8'h29:   k = KRparen;
      8'h7b:   k = KLbrace;
      8'h7d:   k = KRbrace;
      8'h5b:   k = KLbrack;
      8'h5d:   k = KRbrack;
      8'h2e:   k = KDot;
      8'h2c:   k = KComma;
      8'h3a:   k = KColon;
      8'h2b:   k = KPlus;
      8'h2d:   k = KMinus;
      8'h2a:   k = KStar;
      default: k = KEnd;
    endcase
    return k;
  endfunction

  function automatic kind_t kw_kind(input word_t w, input logic [PosBits-1:0] cnt);
    kind_t k;
    logic [15:0] w2;
    logic [23:0] w3;
    logic [31:0] w4;
    logic [39:0] w5;
    logic [47:0] w6;
    w2 = {w[0], w[1]};
    w3 = {w[0], w[1], w[2]};
    w4 = {w[0], w[1], w[2], w[3]};
    w5 = {w[0], w[1], w[2], w[3], w[4]};
    w6 = {w[0], w[1], w[2], w[3], w[4], w[5]};
    k = KIdent;
    case (cnt)
      PosBits'(2): begin
        if (w2 == "fn") k = KwFn;
        else if (w2 == "if") k = KwIf;
      end
      PosBits'(3): begin
        if (w3 == "for") k = KwFor;
        else if (w3 == "let") k = KwLet;
      end
      PosBits'(4): begin
        if (w4 == "else") k = KwElse;
        else if (w4 == "self") k = KwSelf;
        else if (w4 == "true") k = KwTrue;
        else if (w4 == "with") k = KwWith;
      end
      PosBits'(5): begin
        if (w5 == "false") k = KwFalse;
        else if (w5 == "match") k = KwMatch;
        else if (w5 == "print") k = KwPrint;
        else if (w5 == "while") k = KwWhile;
      end
      PosBits'(6): begin
        if (w6 == "return") k = KwReturn;
        else if (w6 == "struct") k = KwStruct;
      end
      default: k = KIdent;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### design/source_text_tokenizer.sv
// source text tokenizer top level: byte stream in, token stream out
// depends on stt_pkg
//
// usage
// - slave channel takes one source byte per transaction; a zero byte ends the text
// - master channel gives one token per transaction, tlast on the final token a
//   byte causes (a byte causes zero to three tokens)
// - each accepted byte is scanned in the cycle it is accepted; its tokens land
//   in a four-entry result queue and reach the master side from the next cycle,
//   behind any token already queued
// - throughput: one byte per cycle while the queue holds at most one token;
//   bytes that yield two or three tokens drain one token per transaction
//   through the single output port of the queue
// - a stalled receiver lets the queue fill; tready drops once it holds two
//   tokens, until room for three tokens returns; no token is lost
// - reset clears scan state, counters (line to one) and the queue; after the
//   end token the scan state returns to the same values
`default_nettype none
module source_text_tokenizer
  import stt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // text_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // token_kind[5:0], error_kind[7:6], start_offset[23:8], tok_length[39:24],
  // line_number[55:40]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast    // last_of_run
);

  localparam logic [PosBits-1:0]  PosMax  = '1;
  localparam logic [LineBits-1:0] LineMax = '1;

  // scan state
  mode_e              mode_q, mode_d;
  word_t              word_q, word_d;
  logic [PosBits-1:0] start_q, start_d;
  logic [PosBits-1:0] cnt_q, cnt_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [LineBits-1:0] line_q, line_d;

  // result queue
  tok_t       fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] used_q, used_d;

  tok_t       res [3];
  logic [1:0] n;
  logic       accept, pop;

  assign s_axis_tready = (used_q <= 3'd1);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (used_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {fifo_q[rd_q].line, fifo_q[rd_q].len, fifo_q[rd_q].start,
                          fifo_q[rd_q].err, fifo_q[rd_q].kind};
  assign m_axis_tlast  = fifo_q[rd_q].last;

  // scan one byte
  always_comb begin
    logic [7:0]         c;
    logic               consumed, ended, alpha, digit;
    logic [PosBits:0]   sum;
    c        = s_axis_tdata;
    consumed = 1'b1;
    ended    = 1'b0;
    alpha    = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    digit    = (c >= 8'h30 && c <= 8'h39);
    mode_d   = mode_q;
    word_d   = word_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    line_d   = line_q;
    n        = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    sum      = '0;

    if (mode_q != M_IDLE) begin
      consumed = 1'b0;
      case (mode_q)
        M_IDENT: begin
          if (alpha || digit) begin
            if (cnt_q < PosBits'(KwMaxLen)) word_d[cnt_q[2:0]] = c;
            cnt_d    = (cnt_q == PosMax) ? cnt_q : cnt_q + 1'b1;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_q), 16'(start_q), ErrNone,
                       kw_kind(word_q, cnt_q)};
            n = n + 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (digit) begin
            cnt_d    = (cnt_q == PosMax) ? cnt_q : cnt_q + 1'b1;
            consumed = 1'b1;
          end else if (mode_q == M_INT && c == 8'h2e) begin
            mode_d   = M_INT_DOT;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_q), 16'(start_q), ErrNone, KNum};
            n = n + 1'b1;
          end
        end
        M_INT_DOT: begin
          if (digit) begin
            sum      = {1'b0, cnt_q} + (PosBits+1)'(2);
            cnt_d    = sum[PosBits] ? PosMax : sum[PosBits-1:0];
            mode_d   = M_FRAC;
            consumed = 1'b1;
          end else begin
            sum    = {1'b0, start_q} + {1'b0, cnt_q};
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_q), 16'(start_q), ErrNone, KNum};
            n = n + 1'b1;
            res[n] = '{1'b0, 16'(line_q), 16'd1,
                       16'(sum[PosBits] ? PosMax : sum[PosBits-1:0]), ErrNone, KDot};
            n = n + 1'b1;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            cnt_d  = (cnt_q == PosMax) ? cnt_q : cnt_q + 1'b1;
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_d), 16'(start_q), ErrNone, KStr};
            n = n + 1'b1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else if (c == 8'h0a) begin
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_q), 16'(start_q), ErrMulti, KErr};
            n = n + 1'b1;
          end else if (c == 8'h00) begin
            res[n] = '{1'b0, 16'(line_q), 16'(cnt_q), 16'(start_q), ErrUnter, KErr};
            n = n + 1'b1;
          end else begin
            cnt_d    = (cnt_q == PosMax) ? cnt_q : cnt_q + 1'b1;
            consumed = 1'b1;
          end
        end
        M_COMMENT: consumed = !(c == 8'h0a || c == 8'h00);
        M_SLASH: begin
          if (c == 8'h2f) begin
            mode_d   = M_COMMENT;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(start_q), ErrNone, KSlash};
            n = n + 1'b1;
          end
        end
        M_GT: begin
          if (c == 8'h3d) begin
            res[n] = '{1'b0, 16'(line_q), 16'd2, 16'(start_q), ErrNone, KGe};
            n = n + 1'b1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(start_q), ErrNone, KGt};
            n = n + 1'b1;
          end
        end
        M_LT: begin
          if (c == 8'h3d || c == 8'h7c) begin
            res[n] = '{1'b0, 16'(line_q), 16'd2, 16'(start_q), ErrNone,
                       (c == 8'h3d) ? KLe : KLpipe};
            n = n + 1'b1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(start_q), ErrNone, KLt};
            n = n + 1'b1;
          end
        end
        M_PIPE: begin
          if (c == 8'h7c || c == 8'h3e) begin
            res[n] = '{1'b0, 16'(line_q), 16'd2, 16'(start_q), ErrNone,
                       (c == 8'h7c) ? KOr : KPipeR};
            n = n + 1'b1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(start_q), ErrChar, KErr};
            n = n + 1'b1;
          end
        end
        M_AMP: begin
          if (c == 8'h26) begin
            res[n] = '{1'b0, 16'(line_q), 16'd2, 16'(start_q), ErrNone, KAnd};
            n = n + 1'b1;
            mode_d   = M_IDLE;
            consumed = 1'b1;
          end else begin
            res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(start_q), ErrChar, KErr};
            n = n + 1'b1;
          end
        end
        default: consumed = 1'b0;
      endcase
      if (!consumed) mode_d = M_IDLE;
    end

    // byte not taken by an open token: scan it from idle
    if (!consumed || mode_q == M_IDLE) begin
      if (c == 8'h00) begin
        res[n] = '{1'b0, 16'(line_d), 16'd0, 16'(pos_q), ErrNone, KEnd};
        n = n + 1'b1;
        ended = 1'b1;
      end else if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
        ended = 1'b0;
      end else if (c == 8'h0a) begin
        if (line_q != LineMax) line_d = line_q + 1'b1;
      end else begin
        start_d = pos_q;
        cnt_d   = PosBits'(1);
        if (alpha) begin
          word_d[0] = c;
          mode_d    = M_IDENT;
        end else if (digit) mode_d = M_INT;
        else if (c == 8'h22) mode_d = M_STRING;
        else if (c == 8'h2f) mode_d = M_SLASH;
        else if (c == 8'h3e) mode_d = M_GT;
        else if (c == 8'h3c) mode_d = M_LT;
        else if (c == 8'h7c) mode_d = M_PIPE;
        else if (c == 8'h26) mode_d = M_AMP;
        else if (single_kind(c) != KEnd) begin
          res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(pos_q), ErrNone, single_kind(c)};
          n = n + 1'b1;
        end else begin
          res[n] = '{1'b0, 16'(line_q), 16'd1, 16'(pos_q), ErrChar, KErr};
          n = n + 1'b1;
        end
      end
    end

    if (n != 2'd0) res[n - 1'b1].last = 1'b1;

    if (ended) begin
      mode_d  = M_IDLE;
      start_d = '0;
      cnt_d   = '0;
      pos_d   = '0;
      line_d  = LineBits'(1);
    end else begin
      pos_d = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
    end
  end

  always_comb begin
    used_d = used_q;
    if (accept) used_d = used_d + {1'b0, n};
    if (pop) used_d = used_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      line_q  <= LineBits'(1);
      wr_q    <= '0;
      rd_q    <= '0;
      used_q  <= '0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        start_q <= start_d;
        cnt_q   <= cnt_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
        wr_q    <= wr_q + n;
      end
      if (pop) rd_q <= rd_q + 1'b1;
      used_q <= used_d;
    end
  end

  // word buffer and queue payload carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n) fifo_q[wr_q + 2'(i)] <= res[i];
      end
    end
  end

  // queue never holds more than its four entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= 3'd4)
    else $error("result queue overflow");

  // a byte is only taken when three tokens fit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> used_q <= 3'd1)
    else $error("byte accepted without queue room");

  // after the end byte the scanner is back at its reset position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tdata == 8'h00) |=> (pos_q == '0 && mode_q == M_IDLE))
    else $error("scan state not cleared after end of text");

  // an accepted byte with tokens makes the output valid next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && n != 2'd0) |=> m_axis_tvalid)
    else $error("tokens lost");

endmodule
`default_nettype wire
